// ===== hw/rtl/mdb_pkg.sv =====
`default_nettype none
package mdb_pkg;

  localparam int unsigned DurWidth = 24;
  localparam int unsigned NumWidth = 7;
  localparam int unsigned PatWidth = 5;

  localparam logic [DurWidth-1:0] DashOnReset   = 24'd4800000;
  localparam logic [DurWidth-1:0] DotOnReset    = 24'd1600000;
  localparam logic [DurWidth-1:0] ElemGapReset  = 24'd1200000;
  localparam logic [DurWidth-1:0] DigPauseReset = 24'd1000000;

  localparam logic [NumWidth-1:0] NumMax = 7'd99;

  typedef enum logic [1:0] {
    CFG_DASH_ON   = 2'd0,
    CFG_DOT_ON    = 2'd1,
    CFG_ELEM_GAP  = 2'd2,
    CFG_DIG_PAUSE = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_e;

  typedef struct packed {
    logic [DurWidth-1:0] dash_on;
    logic [DurWidth-1:0] dot_on;
    logic [DurWidth-1:0] elem_gap;
    logic [DurWidth-1:0] dig_pause;
  } cfg_t;

  typedef struct packed {
    logic led_on;
    logic busy;
    logic digit_done;
    logic number_done;
  } res_t;

  // dash = 1, most significant element first
  localparam logic [PatWidth-1:0] MorseTable [10] = '{
    5'b11111, 5'b01111, 5'b00111, 5'b00011, 5'b00001,
    5'b00000, 5'b10000, 5'b11000, 5'b11100, 5'b11110
  };

  function automatic logic [PatWidth-1:0] morse_pattern(input logic [3:0] digit);
    logic [3:0] d;
    d = (digit >= 4'd10) ? digit - 4'd10 : digit;
    return MorseTable[d];
  endfunction

  // x / 10 for x <= 99 via reciprocal multiply
  function automatic logic [3:0] tens_of(input logic [NumWidth-1:0] num);
    logic [13:0] prod;
    prod = 14'(num) * 14'd103;
    return prod[13:10];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mdb_seq.sv =====
`default_nettype none
module mdb_seq
  import mdb_pkg::*;
#(
  parameter int unsigned CountWidth = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                opcode_i,
  input  wire logic [NumWidth-1:0] number_value_i,
  input  wire cfg_t                cfg_i,
  output res_t                     res_o,
  output logic                     idle_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_ON    = 4'b0010,
    PH_GAP   = 4'b0100,
    PH_PAUSE = 4'b1000
  } phase_e;

  localparam logic [32:0] MaxDur = (33'd1 << CountWidth) - 33'd1;

  phase_e                phase_q, phase_d;
  logic [2:0]            elem_q, elem_d;
  logic [PatWidth-1:0]   pat_q, pat_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [3:0]            ones_q, ones_d;
  logic                  second_q, second_d;

  logic                  cur_bit;
  logic [DurWidth-1:0]   dur_sel;
  logic [32:0]           dur_wide;
  logic [CountWidth-1:0] dur_eff;
  logic [CountWidth:0]   cnt_inc;
  logic                  ends;
  logic [NumWidth-1:0]   num_sat;
  logic [3:0]            tens;
  logic [3:0]            ones;
  logic                  dd, nd;

  assign cur_bit = (elem_q <= 3'd4) ? pat_q[3'd4 - elem_q] : 1'b0;

  always_comb begin
    unique case (phase_q)
      PH_ON:   dur_sel = cur_bit ? cfg_i.dash_on : cfg_i.dot_on;
      PH_GAP:  dur_sel = cfg_i.elem_gap;
      default: dur_sel = cfg_i.dig_pause;
    endcase
  end

  // clip to counter range, zero acts as one
  always_comb begin
    dur_wide = {{(33 - DurWidth){1'b0}}, dur_sel};
    if (dur_wide > MaxDur) begin
      dur_wide = MaxDur;
    end
    if (dur_wide == 33'd0) begin
      dur_wide = 33'd1;
    end
    dur_eff = dur_wide[CountWidth-1:0];
  end

  assign cnt_inc = {1'b0, cnt_q} + {{CountWidth{1'b0}}, 1'b1};
  assign ends    = (cnt_inc >= {1'b0, dur_eff});

  assign num_sat = (number_value_i > NumMax) ? NumMax : number_value_i;
  assign tens    = tens_of(num_sat);
  assign ones    = 4'(num_sat - NumWidth'(tens) * NumWidth'(4'd10));

  always_comb begin
    phase_d  = phase_q;
    elem_d   = elem_q;
    pat_d    = pat_q;
    cnt_d    = cnt_q;
    ones_d   = ones_q;
    second_d = second_q;
    dd       = 1'b0;
    nd       = 1'b0;
    if (opcode_i == OP_START) begin
      if (phase_q == PH_IDLE) begin
        elem_d  = 3'd0;
        cnt_d   = '0;
        phase_d = PH_ON;
        if (tens != 4'd0) begin
          ones_d   = ones;
          second_d = 1'b1;
          pat_d    = morse_pattern(tens);
        end else begin
          ones_d   = 4'd0;
          second_d = 1'b0;
          pat_d    = morse_pattern(ones);
        end
      end
    end else if (phase_q != PH_IDLE) begin
      cnt_d = ends ? '0 : cnt_inc[CountWidth-1:0];
      if (ends) begin
        unique case (phase_q)
          PH_ON: begin
            phase_d = PH_GAP;
          end
          PH_GAP: begin
            if (elem_q >= 3'd4) begin
              phase_d = PH_PAUSE;
            end else begin
              elem_d  = elem_q + 3'd1;
              phase_d = PH_ON;
            end
          end
          default: begin
            dd = 1'b1;
            if (second_q) begin
              second_d = 1'b0;
              pat_d    = morse_pattern(ones_q);
              elem_d   = 3'd0;
              phase_d  = PH_ON;
            end else begin
              nd      = 1'b1;
              phase_d = PH_IDLE;
              elem_d  = 3'd0;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      elem_q   <= 3'd0;
      pat_q    <= '0;
      cnt_q    <= '0;
      ones_q   <= 4'd0;
      second_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      elem_q   <= elem_d;
      pat_q    <= pat_d;
      cnt_q    <= cnt_d;
      ones_q   <= ones_d;
      second_q <= second_d;
    end
  end

  assign res_o.led_on      = (phase_d == PH_ON);
  assign res_o.busy        = (phase_d != PH_IDLE);
  assign res_o.digit_done  = dd;
  assign res_o.number_done = nd;
  assign idle_o            = (phase_q == PH_IDLE);

endmodule
`default_nettype wire

// ===== hw/rtl/morse_digit_led_blinker.sv =====
// An item's result is registered and on the outputs the cycle after acceptance.
// Throughput: one item per cycle unless out_stall_i holds the result; the phase
//   counter and machine finish each item in one pass; output reg frees as taken.
// Reset (rst_ni low, asynchronous): idle, counters cleared, no result pending,
//   durations back to dash 4800000, dot 1600000, gap 1200000, pause 1000000.
`default_nettype none
module morse_digit_led_blinker
  import mdb_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                opcode_i,
  input  wire logic [NumWidth-1:0] number_value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     led_on_o,
  output logic                     busy_res_o,
  output logic                     digit_done_o,
  output logic                     number_done_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [DurWidth-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  res_t res_d, res_q;
  logic out_valid_q;
  logic in_acc;
  logic seq_idle;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dash_on   <= DashOnReset;
      cfg_q.dot_on    <= DotOnReset;
      cfg_q.elem_gap  <= ElemGapReset;
      cfg_q.dig_pause <= DigPauseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DASH_ON:   cfg_q.dash_on   <= cfg_wdata_i;
        CFG_DOT_ON:    cfg_q.dot_on    <= cfg_wdata_i;
        CFG_ELEM_GAP:  cfg_q.elem_gap  <= cfg_wdata_i;
        CFG_DIG_PAUSE: cfg_q.dig_pause <= cfg_wdata_i;
        default:       cfg_q           <= cfg_q;
      endcase
    end
  end

  mdb_seq #(
    .CountWidth(COUNT_WIDTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (in_acc),
    .opcode_i       (opcode_i),
    .number_value_i (number_value_i),
    .cfg_i          (cfg_q),
    .res_o          (res_d),
    .idle_o         (seq_idle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign led_on_o      = res_q.led_on;
  assign busy_res_o    = res_q.busy;
  assign digit_done_o  = res_q.digit_done;
  assign number_done_o = res_q.number_done;

  a_led_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && led_on_o |-> busy_res_o)
    else $error("LED lit while not busy");

  a_number_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && number_done_o |-> digit_done_o && !busy_res_o)
    else $error("number done without digit done or still busy");

  a_start_lights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_START) && seq_idle |=> out_valid_o && led_on_o && busy_res_o)
    else $error("start from idle did not light the LED");

endmodule
`default_nettype wire
